[rtl/bfa_pkg.sv]
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

  localparam int unsigned FRAME_W         = 20;  // absolute frame number
  localparam int unsigned CNT_W           = 13;  // pool size and run length
  localparam int unsigned IDX_W           = 17;  // pool-relative frame index
  localparam int unsigned MAP_W           = 8;   // bitmap word
  localparam int unsigned FRAMES_PER_WORD = 4;
  localparam int unsigned APB_AW          = 3;
  localparam int unsigned APB_DW          = 32;

  localparam logic [MAP_W-1:0] ALLOC_BITS = 8'h55;
  localparam logic [MAP_W-1:0] INACC_BITS = 8'hAA;
  localparam logic [MAP_W-1:0] SLOT_BITS  = 8'hFF;
  localparam logic [MAP_W-1:0] TOP_SLOT   = 8'b11000000;

  localparam logic [CNT_W-1:0] NUM_FRAMES_RST = 13'd4096;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_MARK    = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_INACC = 2'd3
  } status_e;

  typedef enum logic {
    REG_POOL_BASE  = 1'b0,
    REG_NUM_FRAMES = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FRAME_W-1:0] frame_no;
    logic [CNT_W-1:0]   run_length;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] granted_frame;
    logic [1:0]         status;
  } rsp_t;

  // Command to the word unit: which operation, on frames lo <= f < hi.
  typedef struct packed {
    req_type_e        op;
    logic [IDX_W-1:0] word_base;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } wu_cmd_t;

  typedef struct packed {
    logic             found;     // a free frame lies in range
    logic [1:0]       slot;      // lowest free slot
    logic             inacc;     // an inaccessible frame lies in range
    logic             last;      // this word holds the last frame below hi
    logic [MAP_W-1:0] new_word;
  } wu_res_t;

endpackage

[rtl/bfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/bfa_word_unit.sv]
// Shared word unit: find, mark or release the frames of one bitmap word.
module bfa_word_unit
  import bfa_pkg::*;
(
  input  wu_cmd_t          cmd_i,
  input  logic [MAP_W-1:0] word_i,
  output wu_res_t          res_o
);

  logic [FRAMES_PER_WORD-1:0] in_rng;
  logic [FRAMES_PER_WORD-1:0] free;
  logic [MAP_W-1:0]           rng_mask;
  logic [IDX_W-1:0]           frame;
  logic [IDX_W-1:0]           next_base;

  always_comb begin
    rng_mask = '0;
    for (int s = 0; s < FRAMES_PER_WORD; s++) begin
      frame     = cmd_i.word_base + IDX_W'(s);
      in_rng[s] = (frame >= cmd_i.lo) && (frame < cmd_i.hi);
      free[s]   = in_rng[s] && !word_i[2*s];
      if (in_rng[s]) begin
        rng_mask = rng_mask | (TOP_SLOT >> (2 * (FRAMES_PER_WORD - 1 - s)));
      end
    end
  end

  always_comb begin
    next_base       = cmd_i.word_base + IDX_W'(FRAMES_PER_WORD);
    res_o.found     = |free;
    res_o.slot      = 2'd0;
    for (int s = FRAMES_PER_WORD - 1; s >= 0; s--) begin
      if (free[s]) begin
        res_o.slot = 2'(s);
      end
    end
    res_o.inacc     = |(word_i & rng_mask & INACC_BITS);
    res_o.last      = next_base >= cmd_i.hi;
    res_o.new_word  = word_i;
    case (cmd_i.op)
      REQ_ALLOC: begin
        res_o.new_word = word_i | ((SLOT_BITS & ALLOC_BITS) << (2 * res_o.slot)
                                   & (ALLOC_BITS & {{(MAP_W-2){1'b0}}, 2'b11}
                                      << (2 * res_o.slot)));
      end
      REQ_RELEASE: res_o.new_word = word_i & ~rng_mask;
      REQ_MARK:    res_o.new_word = word_i | rng_mask;
      default:     res_o.new_word = word_i;
    endcase
  end

endmodule

[rtl/bfa_regs.sv]
// APB configuration registers: base frame and pool size.
module bfa_regs
  import bfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [FRAME_W-1:0] pool_base_o,
  output logic [CNT_W-1:0]   num_frames_o
);

  logic [FRAME_W-1:0] pool_base_q;
  logic [CNT_W-1:0]   num_frames_q;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      num_frames_q <= NUM_FRAMES_RST;
    end else if (wr_en) begin
      case (idx)
        REG_POOL_BASE:  pool_base_q  <= pwdata[FRAME_W-1:0];
        REG_NUM_FRAMES: num_frames_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POOL_BASE:  prdata = APB_DW'(pool_base_q);
      REG_NUM_FRAMES: prdata = APB_DW'(num_frames_q);
      default:        prdata = '0;
    endcase
  end

  assign pool_base_o  = pool_base_q;
  assign num_frames_o = num_frames_q;

endmodule

[rtl/bitmap_frame_allocator.sv]
// Bitmap frame allocator top level: sequencer, bitmap RAM and output register.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-----------------------------
//   in      | input     | in_valid/in_ready  | req_t: type, frame, run
//   out     | output    | out_valid/out_ready| rsp_t: granted frame, status
//   cfg     | input     | APB write/read     | pool base, num_frames
//
// One request at a time. The bitmap word unit handles one RAM word per cycle:
// allocate scans the pool words until it finds a free frame or reaches the
// end of the pool, mark writes every word covered by the run, release checks
// one word; out-of-range, empty-run and unknown requests skip the scan.
// After reset a clearing pass writes MAX_FRAMES/4 words before the first
// request is taken. A stalled output holds the finished word; the next
// request is taken meanwhile but cannot finish.
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned MAP_WORDS = MAX_FRAMES / FRAMES_PER_WORD;
  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [FRAME_W-1:0] pool_base;
  logic [CNT_W-1:0]   num_frames;
  logic [CNT_W-1:0]   n_use;

  state_e             state_q, state_d;
  logic [AW-1:0]      scan_q, scan_d;
  logic [IDX_W-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [1:0]         req_q;
  logic [FRAME_W-1:0] rel_q;
  logic [CNT_W-1:0]   run_q;
  rsp_t               pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_data_q, out_data_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [MAP_W-1:0]   ram_wdata, ram_rdata;

  wu_cmd_t            wu_cmd;
  wu_res_t            wu_res;
  logic [IDX_W-1:0]   word_base;
  logic [IDX_W-1:0]   run_end;

  bfa_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pool_base_o  (pool_base),
    .num_frames_o (num_frames)
  );

  bfa_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bfa_word_unit u_wu (
    .cmd_i  (wu_cmd),
    .word_i (ram_rdata),
    .res_o  (wu_res)
  );

  // Frames in use: the smaller of the register and the bitmap size.
  assign n_use = (IDX_W'(num_frames) < IDX_W'(MAX_FRAMES)) ? num_frames
                                                           : CNT_W'(MAX_FRAMES);

  assign word_base      = IDX_W'({scan_q, 2'b00});
  assign wu_cmd.op      = req_type_e'(req_q);
  assign wu_cmd.word_base = word_base;
  assign wu_cmd.lo      = lo_q;
  assign wu_cmd.hi      = hi_q;

  assign run_end   = IDX_W'(rel_q[CNT_W-1:0]) + IDX_W'(run_q);
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    pend_q     <= pend_d;
    out_data_q <= out_data_d;
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i.req_type;
      rel_q <= in_data_i.frame_no - pool_base;
      run_q <= in_data_i.run_length;
    end
  end

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = scan_q;
    ram_wdata   = wu_res.new_word;
    ram_raddr   = scan_q + AW'(1);

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        scan_d    = scan_q + AW'(1);
        if (scan_q == AW'(MAP_WORDS - 1)) begin
          scan_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        pend_d.granted_frame = '0;
        pend_d.status        = ST_OK;
        state_d              = S_SCAN;
        case (req_q)
          REQ_ALLOC: begin
            lo_d = '0;
            hi_d = IDX_W'(n_use);
          end
          REQ_RELEASE: begin
            lo_d = IDX_W'(rel_q[CNT_W-1:0]);
            hi_d = IDX_W'(rel_q[CNT_W-1:0]) + IDX_W'(1);
          end
          REQ_MARK: begin
            lo_d = IDX_W'(rel_q[CNT_W-1:0]);
            hi_d = (run_end > IDX_W'(n_use)) ? IDX_W'(n_use) : run_end;
            if (run_q == '0) begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_DONE;
        endcase
        if ((req_q == REQ_RELEASE || req_q == REQ_MARK) &&
            rel_q >= FRAME_W'(n_use)) begin
          pend_d.status = ST_RANGE;
          state_d       = S_DONE;
        end
        // Prime the read of the first word.
        scan_d    = AW'(lo_d >> 2);
        ram_raddr = scan_d;
      end
      S_SCAN: begin
        case (req_q)
          REQ_ALLOC: begin
            if (wu_res.found) begin
              ram_we               = 1'b1;
              pend_d.granted_frame = FRAME_W'(word_base + IDX_W'(wu_res.slot))
                                     + pool_base;
              state_d              = S_DONE;
            end else if (wu_res.last) begin
              pend_d.status = ST_FULL;
              state_d       = S_DONE;
            end else begin
              scan_d = scan_q + AW'(1);
            end
          end
          REQ_RELEASE: begin
            if (wu_res.inacc) begin
              pend_d.status = ST_INACC;
            end else begin
              ram_we = 1'b1;
            end
            state_d = S_DONE;
          end
          REQ_MARK: begin
            ram_we = 1'b1;
            if (wu_res.last) begin
              state_d = S_DONE;
            end else begin
              scan_d = scan_q + AW'(1);
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = pend_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while another is in progress");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (ram_we && ram_wdata == '0 && !in_ready_o))
    else $error("clearing pass wrote nonzero data or took a request");

  a_full_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |-> out_data_o.granted_frame == '0)
    else $error("failed request carries a granted frame");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result lost or changed");

endmodule
